>>> design/arpc_pkg.sv
// Shared types, codes and widths for the ARP neighbor cache.
package arpc_pkg;

    localparam int ENTRIES_DEF   = 16;

    localparam int IP_W          = 32;
    localparam int MAC_W         = 48;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_INDEX_W = 4;

    localparam int IN_TDATA_W    = 80;
    localparam int IN_TUSER_W    = 1;
    localparam int OUT_TDATA_W   = 56;
    localparam int OUT_TUSER_W   = 2;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic             lookup;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } req_t;

endpackage

>>> design/arp_neighbor_cache.sv
// Top level of the ARP neighbor cache.
//
// Requests enter on the s_axis channel: tuser[0] selects insert (0) or lookup (1),
// tdata carries the IPv4 address and, for an insert, the MAC address. Every request
// beat produces exactly one result beat on m_axis: tuser carries the status (present
// or hit, newly added, lookup miss, table full) and tdata the stored MAC address and
// the entry index.
// An ingress register decodes each beat into a four-deep request queue; the table
// engine drains the queue one request at a time. The engine handles each request in
// three steps (dequeue with a parallel address compare, priority select with table
// write, result load) and takes no new request before the last result is loaded.
// An accepted request beat passes the ingress register, the queue, the engine steps
// and the output register before its result beat appears.
// Reset empties the table (fill count zero), the queue and the output register.
// When the receiver holds m_axis_tready low, the finished result waits in the output
// register, the engine stops, the queue fills up and s_axis_tready then drops.
module arp_neighbor_cache #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] ip_addr, [79:32] mac_addr
    input  logic [arpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic [arpc_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [47:0] mac_found, [51:48] entry_index, [55:52] zero
    output logic [arpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [arpc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import arpc_pkg::*;

    logic push;
    req_t push_req;
    logic q_full;
    logic q_empty;
    logic pop;
    req_t head_req;

    arpc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_req      (push_req),
        .q_full        (q_full)
    );

    arpc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .full     (q_full),
        .pop      (pop),
        .head_req (head_req),
        .empty    (q_empty)
    );

    arpc_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .head_req      (head_req),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> design/arpc_front.sv
// Ingress stage: takes request beats, decodes them and feeds the request queue.
module arpc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [arpc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic [arpc_pkg::IN_TUSER_W-1:0] s_axis_tuser,
    output logic                           push,
    output arpc_pkg::req_t                 push_req,
    input  logic                           q_full
);
    import arpc_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    logic accept;

    assign push          = valid_reg && !q_full;
    assign s_axis_tready = !valid_reg || !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_req      = req_reg;

    assign valid_next = accept || (valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.lookup <= (s_axis_tuser[0] == FUNC_LOOKUP);
            req_reg.ip     <= s_axis_tdata[IP_W-1:0];
            req_reg.mac    <= s_axis_tdata[IP_W+MAC_W-1:IP_W];
        end
    end

endmodule

>>> design/arpc_queue.sv
// Short request queue between the ingress stage and the table engine.
module arpc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  arpc_pkg::req_t push_req,
    output logic           full,
    input  logic           pop,
    output arpc_pkg::req_t head_req,
    output logic           empty
);
    import arpc_pkg::*;

    req_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_req = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

>>> design/arpc_back.sv
// Table engine: searches and appends the neighbor table and drives the result beat.
module arpc_back #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  arpc_pkg::req_t                  head_req,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [arpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [arpc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import arpc_pkg::*;

    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int IDXX_W = (IDX_W > ENTRY_INDEX_W) ? IDX_W : ENTRY_INDEX_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RES  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic [IP_W-1:0]     entry_ip [ENTRIES];
    logic [MAC_W-1:0]    entry_mac [ENTRIES];

    logic [ENTRIES-1:0]  hit_vec_reg;
    logic [ENTRIES-1:0]  hit_vec;
    logic                lookup_reg;
    logic [IP_W-1:0]     ip_reg;
    logic [MAC_W-1:0]    mac_reg;
    logic [MAC_W-1:0]    rd_mac_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [IDX_W-1:0]    hit_idx;
    logic                hit_any;
    logic                table_full;
    logic                wr_en;
    logic                load_out;
    logic [IDXX_W-1:0]   idx_wide;
    logic [MAC_W-1:0]    mac_out;

    logic [MAC_W-1:0]         out_mac_reg;
    logic [ENTRY_INDEX_W-1:0] out_idx_reg;
    logic [STATUS_W-1:0]      out_status_reg;

    assign pop        = (state_reg == S_IDLE) && !q_empty;
    assign hit_any    = |hit_vec_reg;
    assign table_full = (fill_reg == FILL_W'(ENTRIES));
    assign load_out   = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    // Only entries below the fill count take part in the compare.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = (FILL_W'(i) < fill_reg) && (entry_ip[i] == head_req.ip);
        end
    end

    // Lowest matching index wins when an address is stored twice.
    always_comb
    begin
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        idx_next    = '0;
        wr_en       = 1'b0;
        if (hit_any)
        begin
            status_next = ST_OK;
            idx_next    = hit_idx;
        end
        else if (lookup_reg)
        begin
            status_next = ST_MISS;
        end
        else if (table_full)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            status_next = ST_ADDED;
            idx_next    = fill_reg[IDX_W-1:0];
            wr_en       = (state_reg == S_RES);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = wr_en ? fill_reg + FILL_W'(1) : fill_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hit_vec_reg <= hit_vec;
            lookup_reg  <= head_req.lookup;
            ip_reg      <= head_req.ip;
            mac_reg     <= head_req.mac;
        end
        if (state_reg == S_RES)
        begin
            status_reg <= status_next;
            idx_reg    <= idx_next;
        end
    end

    // Address table: each entry is compared at its own place.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_ip[fill_reg[IDX_W-1:0]] <= ip_reg;
        end
    end

    // MAC storage: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mac[fill_reg[IDX_W-1:0]] <= mac_reg;
        end
        rd_mac_reg <= entry_mac[hit_idx];
    end

    assign idx_wide = IDXX_W'(idx_reg);
    assign mac_out  = (status_reg == ST_OK) ? rd_mac_reg : '0;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_mac_reg    <= mac_out;
            out_idx_reg    <= idx_wide[ENTRY_INDEX_W-1:0];
            out_status_reg <= status_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_idx_reg, out_mac_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

>>> tb/tb_top.sv
// Self-checking stream testbench for the ARP neighbor cache, with random idling on both sides.
module tb_top;
    import arpc_pkg::*;

    localparam int TABLE_SIZE  = ENTRIES_DEF;
    localparam int POOL_SIZE   = 24;
    localparam int RANDOM_REQS = 1450;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 12;

    typedef struct {
        req_t req;
        bit   drain_first;
    } queued_req_t;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic [MAC_W-1:0]         mac_found;
        logic [ENTRY_INDEX_W-1:0] entry_index;
    } cache_result_t;

    logic clk;
    logic rst_n;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    queued_req_t   request_backlog[$];
    cache_result_t pending_results[$];

    // Shadow copy of the neighbor table.
    logic [IP_W-1:0]  shadow_ip[TABLE_SIZE];
    logic [MAC_W-1:0] shadow_mac[TABLE_SIZE];
    int               shadow_fill;

    logic [IP_W-1:0] addr_pool[POOL_SIZE];

    int  err_cnt     = 0;
    int  offered_cnt = 0;
    int  accepted_cnt = 0;
    int  idle_cycles = 0;
    int  gap_left    = 0;
    int  stall_left  = 0;
    bit  calm_tx     = 1'b0;
    bit  calm_rx     = 1'b0;

    arp_neighbor_cache dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s, got %h, want %h", $time, what, got, want);
        err_cnt++;
    endtask

    task automatic queue_request(input logic func, input logic [IP_W-1:0] ip,
                                 input logic [MAC_W-1:0] mac, input bit drain_first);
        queued_req_t q;
        q.req.lookup   = func;
        q.req.ip       = ip;
        q.req.mac      = mac;
        q.drain_first  = drain_first;
        request_backlog.push_back(q);
    endtask

    // Searches the valid entries in index order; the lowest match wins.
    function automatic cache_result_t resolve_request(input req_t r);
        cache_result_t res;
        int            hit;
        res.status      = ST_MISS;
        res.mac_found   = '0;
        res.entry_index = '0;
        hit = -1;
        for (int i = 0; i < shadow_fill; i++)
        begin
            if (hit < 0 && shadow_ip[i] == r.ip)
                hit = i;
        end
        if (hit >= 0)
        begin
            res.status      = ST_OK;
            res.mac_found   = shadow_mac[hit];
            res.entry_index = hit[ENTRY_INDEX_W-1:0];
        end
        else if (r.lookup == FUNC_LOOKUP)
            res.status = ST_MISS;
        else if (shadow_fill >= TABLE_SIZE)
            res.status = ST_FULL;
        else
        begin
            shadow_ip[shadow_fill]  = r.ip;
            shadow_mac[shadow_fill] = r.mac;
            res.status      = ST_ADDED;
            res.entry_index = shadow_fill[ENTRY_INDEX_W-1:0];
            shadow_fill++;
        end
        return res;
    endfunction

    // Mostly short gaps, a few long ones, none at all during a calm stretch.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[MAC_W-1:0];
    endfunction

    // Request driver.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!(s_axis_tvalid && accepted_cnt != offered_cnt))
        begin
            if ($urandom_range(0, 199) == 0)
                calm_tx = ~calm_tx;
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (request_backlog.size() != 0 &&
                     !(request_backlog[0].drain_first && pending_results.size() != 0))
            begin
                queued_req_t q;
                q = request_backlog.pop_front();
                s_axis_tdata  <= {q.req.mac, q.req.ip};
                s_axis_tuser  <= q.req.lookup;
                s_axis_tvalid <= 1'b1;
                offered_cnt++;
                gap_left = pick_gap(calm_tx);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver with random back-pressure.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            int n;
            if ($urandom_range(0, 199) == 0)
                calm_rx = ~calm_rx;
            n = ($urandom_range(0, 3) == 0) ? pick_gap(calm_rx) : 0;
            if (n > 0)
            begin
                stall_left = n - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predicts on each accepted request beat, checks each result beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            bit moved;
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                req_t r;
                r.lookup = s_axis_tuser[0];
                r.ip     = s_axis_tdata[IP_W-1:0];
                r.mac    = s_axis_tdata[IP_W+MAC_W-1:IP_W];
                pending_results.push_back(resolve_request(r));
                accepted_cnt++;
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                if (pending_results.size() == 0)
                    report_mismatch("result beat with nothing pending",
                                    64'(m_axis_tdata), 64'(0));
                else
                begin
                    cache_result_t want;
                    want = pending_results.pop_front();
                    if (m_axis_tuser[STATUS_W-1:0] !== want.status)
                        report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                    if (m_axis_tdata[MAC_W-1:0] !== want.mac_found)
                        report_mismatch("mac_found", 64'(m_axis_tdata[MAC_W-1:0]),
                                        64'(want.mac_found));
                    if (m_axis_tdata[MAC_W+ENTRY_INDEX_W-1:MAC_W] !== want.entry_index)
                        report_mismatch("entry_index",
                                        64'(m_axis_tdata[MAC_W+ENTRY_INDEX_W-1:MAC_W]),
                                        64'(want.entry_index));
                    if (m_axis_tdata[OUT_TDATA_W-1:MAC_W+ENTRY_INDEX_W] !== '0)
                        report_mismatch("tdata padding",
                                        64'(m_axis_tdata[OUT_TDATA_W-1:MAC_W+ENTRY_INDEX_W]),
                                        64'(0));
                end
            end
            if (moved)
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int r;
        logic [IP_W-1:0] ip;

        shadow_fill = 0;
        rst_n = 1'b0;

        // Directed part: empty-table misses, address and MAC extremes, a repeated
        // insert that must keep the first MAC, hits, near misses and ignored MAC bits.
        queue_request(FUNC_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b0);
        queue_request(FUNC_INSERT, 32'h0000_0000, 48'h0, 1'b0);
        queue_request(FUNC_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_request(FUNC_INSERT, 32'h0000_0000, 48'h1234_5678_9ABC, 1'b0);
        queue_request(FUNC_INSERT, 32'hFFFF_FFFF, 48'h0, 1'b0);
        queue_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 48'h5555_5555_5555, 1'b0);
        queue_request(FUNC_LOOKUP, 32'h0000_0000, 48'h0, 1'b0);
        queue_request(FUNC_LOOKUP, 32'h0000_0001, 48'h0, 1'b0);
        queue_request(FUNC_LOOKUP, 32'h7FFF_FFFF, 48'h0, 1'b0);
        queue_request(FUNC_LOOKUP, 32'h8000_0000, 48'h0, 1'b0);
        queue_request(FUNC_INSERT, 32'h8000_0000, 48'h8000_0000_0000, 1'b0);
        queue_request(FUNC_INSERT, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b0);
        queue_request(FUNC_INSERT, 32'hA5A5_5A5A, 48'hAAAA_AAAA_AAAA, 1'b0);
        queue_request(FUNC_LOOKUP, 32'h8000_0000, 48'h0, 1'b1);
        queue_request(FUNC_LOOKUP, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
        queue_request(FUNC_LOOKUP, 32'hA5A5_5A5B, 48'h0, 1'b0);
        queue_request(FUNC_LOOKUP, 32'h25A5_5A5A, 48'h0, 1'b0);
        queue_request(FUNC_LOOKUP, 32'hA5A5_5A5A, 48'h0, 1'b0);

        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom();

        // Random part: pooled addresses fill the table, then hit it, repeat
        // inserts and get dropped once it is full. Single-bit variants probe the
        // full-width compare, and fully random addresses mostly miss.
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            r = $urandom_range(0, 99);
            ip = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (r >= 60 && r < 75)
                ip[$urandom_range(0, IP_W - 1)] ^= 1'b1;
            else if (r >= 75)
                ip = $urandom();
            queue_request(($urandom_range(0, 99) < 45) ? FUNC_INSERT : FUNC_LOOKUP,
                          ip, random_mac(), $urandom_range(0, 149) == 0);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_backlog.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
